>>> rtl/serial_frame_deframer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the serial frame deframer
// Clocked assertion wrappers, compiled away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH
// check a property on every rising edge, skipped while reset is held
`define SFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property on every rising edge, reset included
`define SFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFD_ASSERT(name, prop, msg)
`define SFD_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> rtl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared constants, register indexes and the result type of the deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 16;
  localparam int LEN_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DISC_TIMEOUT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_JOYSTICK_LEN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LEN       = CFG_IDX_W'(3);

  localparam logic [TICK_W-1:0] FRAME_TIMEOUT_RST = TICK_W'(100);
  localparam logic [TICK_W-1:0] DISC_TIMEOUT_RST  = TICK_W'(1000);
  localparam logic [LEN_W-1:0]  JOYSTICK_LEN_RST  = LEN_W'(36);
  localparam logic [LEN_W-1:0]  INIT_LEN_RST      = LEN_W'(16);

  localparam logic [31:0] HEADER_WORD = 32'h5354_4152;  // "STAR"
  localparam logic [7:0]  TYPE_JOYSTICK = 8'h01;
  localparam logic [7:0]  TYPE_INIT     = 8'h02;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_JOYSTICK = 1'b0;
  localparam logic KIND_INIT     = 1'b1;

  typedef struct packed {
    logic       frame_kind;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       payload_last;
    logic       first_init;
    logic       init_repeat;
    logic       link_lost;
  } res_t;

  // zero means one byte, anything above the ceiling is clipped
  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [CNT_W-1:0] r;
    if (len == '0) begin
      r = CNT_W'(1);
    end else if (32'(len) > MAX_PAYLOAD) begin
      r = CNT_W'(MAX_PAYLOAD);
    end else begin
      r = CNT_W'(len);
    end
    return r;
  endfunction

endpackage

>>> rtl/serial_frame_deframer.sv
// ---------------------------------------------------------------------------
// serial_frame_deframer
// Header-synchronized deframer for a serial byte stream with tick-driven
// frame timeout and disconnect watchdog; payload bytes stream out directly.
// ---------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready   | in_operation, in_rx_byte
//   out     | output    | out_valid / out_ready | frame flags, payload byte
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle while in_ready is high: parser state and any result are
// registered at the accepting edge, into the output register or the skid.
// A two-entry output stage (output register plus skid) keeps in_ready high
// while one finished result waits; in_ready drops only when both are full.
// cfg_ready is always high. Reset restores register defaults and header search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_kind,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_payload_valid,
  output logic                          out_payload_last,
  output logic                          out_first_init,
  output logic                          out_init_repeat,
  output logic                          out_link_lost,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfd_pkg::*;

`include "serial_frame_deframer_macros.svh"

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  logic [TICK_W-1:0] frame_to_r, disc_to_r;
  logic [LEN_W-1:0]  joy_len_r, init_len_r;

  phase_t            phase_r, phase_nxt;
  logic [31:0]       window_r, window_nxt;
  logic [2:0]        fill_r, fill_nxt;
  logic              kind_r, kind_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;
  logic              init_r, init_nxt;

  res_t res;
  logic res_v;

  logic out_v_r, skid_v_r;
  res_t out_r, skid_r;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] cur_len;
  logic [CNT_W-1:0] count_inc;

  assign in_ready  = !skid_v_r;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_v_r || out_ready;
  assign cur_len   = eff_len(kind_r ? init_len_r : joy_len_r);
  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    fill_nxt   = fill_r;
    kind_nxt   = kind_r;
    count_nxt  = count_r;
    idle_nxt   = idle_r;
    init_nxt   = init_r;
    res        = '0;
    res_v      = 1'b0;

    if (in_operation == OP_TICK) begin
      if (idle_r != '1) begin
        idle_nxt = idle_r + TICK_W'(1);
      end
      if (idle_nxt > frame_to_r) begin
        phase_nxt = PH_HEADER;
        fill_nxt  = '0;
        count_nxt = '0;
      end
      if (init_r && idle_nxt > disc_to_r) begin
        init_nxt      = 1'b0;
        res.link_lost = 1'b1;
        res_v         = 1'b1;
      end
    end else begin
      idle_nxt = '0;
      unique case (phase_r)
        PH_TYPE: begin
          if (in_rx_byte == TYPE_JOYSTICK || in_rx_byte == TYPE_INIT) begin
            kind_nxt  = (in_rx_byte == TYPE_INIT) ? KIND_INIT : KIND_JOYSTICK;
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = PH_HEADER;
            fill_nxt  = '0;
          end
          count_nxt = '0;
        end
        PH_PAYLOAD: begin
          count_nxt         = count_inc;
          res.frame_kind    = kind_r;
          res.payload_byte  = in_rx_byte;
          res.payload_valid = 1'b1;
          res_v             = 1'b1;
          if (count_inc >= cur_len) begin
            res.payload_last = 1'b1;
            if (kind_r == KIND_INIT) begin
              res.first_init  = !init_r;
              res.init_repeat = init_r;
              init_nxt        = !init_r;
            end
            phase_nxt = PH_HEADER;
            fill_nxt  = '0;
            count_nxt = '0;
          end
        end
        default: begin
          // header search; the unused code behaves the same
          window_nxt = {window_r[23:0], in_rx_byte};
          if (fill_r < 3'd4) begin
            fill_nxt = fill_r + 3'd1;
          end
          if (fill_nxt >= 3'd4 && window_nxt == HEADER_WORD) begin
            phase_nxt = PH_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_to_r <= FRAME_TIMEOUT_RST;
      disc_to_r  <= DISC_TIMEOUT_RST;
      joy_len_r  <= JOYSTICK_LEN_RST;
      init_len_r <= INIT_LEN_RST;
      phase_r    <= PH_HEADER;
      window_r   <= '0;
      fill_r     <= '0;
      kind_r     <= 1'b0;
      count_r    <= '0;
      idle_r     <= '0;
      init_r     <= 1'b0;
      out_v_r    <= 1'b0;
      skid_v_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FRAME_TIMEOUT: frame_to_r <= cfg_data;
          REG_DISC_TIMEOUT:  disc_to_r  <= cfg_data;
          REG_JOYSTICK_LEN:  joy_len_r  <= cfg_data[LEN_W-1:0];
          REG_INIT_LEN:      init_len_r <= cfg_data[LEN_W-1:0];
          default: ;  // drop writes to unknown indexes
        endcase
      end

      if (accept) begin
        phase_r  <= phase_nxt;
        window_r <= window_nxt;
        fill_r   <= fill_nxt;
        kind_r   <= kind_nxt;
        count_r  <= count_nxt;
        idle_r   <= idle_nxt;
        init_r   <= init_nxt;
      end

      if (out_free) begin
        // advance: skid first, else the new result
        if (skid_v_r) begin
          out_r    <= skid_r;
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_r   <= res;
          out_v_r <= accept && res_v;
        end
      end else if (accept && res_v) begin
        // hold the output, park the new result
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_frame_kind    = out_r.frame_kind;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_valid = out_r.payload_valid;
  assign out_payload_last  = out_r.payload_last;
  assign out_first_init    = out_r.first_init;
  assign out_init_repeat   = out_r.init_repeat;
  assign out_link_lost     = out_r.link_lost;

  `SFD_ASSERT(a_skid_behind_out, skid_v_r |-> out_v_r, "skid holds data while output is empty")
  `SFD_ASSERT(a_count_bound, 32'(count_r) < MAX_PAYLOAD, "payload count past ceiling")
  `SFD_ASSERT(a_flag_on_last, out_v_r && (out_r.first_init || out_r.init_repeat) |-> out_r.payload_last && out_r.frame_kind == KIND_INIT, "init flag off an init last byte")
  `SFD_ASSERT(a_lost_alone, out_v_r && out_r.link_lost |-> !out_r.payload_valid, "link loss mixed with payload")
  `SFD_ASSERT(a_result_lands, $past(accept && res_v && out_free && !skid_v_r) |-> out_v_r, "result not registered")

endmodule
